@@ src/ura_pkg.sv @@
// Shared types, constants and lookup functions for the ultrasonic range alarm.
// No dependencies; every other file in src uses this package by scoped names.
package ura_pkg;

	typedef logic [2:0] band_t;
	typedef logic [4:0][15:0] limits_t;

	localparam band_t BAND_OFF = 3'd5;
	localparam int TONE_W = 14;

	// Configuration register indexes
	localparam logic [2:0] CFG_LIMIT_RED     = 3'd0;
	localparam logic [2:0] CFG_LIMIT_WHITE   = 3'd1;
	localparam logic [2:0] CFG_LIMIT_BLUE    = 3'd2;
	localparam logic [2:0] CFG_LIMIT_GREEN   = 3'd3;
	localparam logic [2:0] CFG_LIMIT_PINK    = 3'd4;
	localparam logic [2:0] CFG_TRIGGER_TICKS = 3'd5;

	localparam logic [15:0] RST_LIMIT_RED   = 16'd292;
	localparam logic [15:0] RST_LIMIT_WHITE = 16'd584;
	localparam logic [15:0] RST_LIMIT_BLUE  = 16'd875;
	localparam logic [15:0] RST_LIMIT_GREEN = 16'd1167;
	localparam logic [15:0] RST_LIMIT_PINK  = 16'd1750;
	localparam logic [7:0]  RST_TRIG_TICKS  = 8'd10;

	typedef struct packed {
		logic        trig_out;
		logic        done;
		logic        run;
		band_t       band;
		logic        band_chg;
		logic [15:0] echo_width;
	} ctrl_stat_t;

	typedef struct packed {
		logic red;
		logic green;
		logic blue;
	} led_t;

	function automatic logic [TONE_W-1:0] tone_wrap(input band_t b);
		logic [TONE_W-1:0] w;
		case (b)
			3'd0: w = 14'd9999;
			3'd1: w = 14'd999;
			3'd2: w = 14'd499;
			3'd3: w = 14'd249;
			3'd4: w = 14'd165;
			default: w = 14'd0;
		endcase
		return w;
	endfunction

	function automatic logic [TONE_W-1:0] tone_high(input band_t b);
		logic [TONE_W-1:0] h;
		case (b)
			3'd0: h = 14'd4999;
			3'd1: h = 14'd499;
			3'd2: h = 14'd249;
			3'd3: h = 14'd124;
			3'd4: h = 14'd82;
			default: h = 14'd0;
		endcase
		return h;
	endfunction

	// red, white, blue, green, pink, dark
	function automatic led_t led_color(input band_t b);
		led_t c;
		case (b)
			3'd0: c = '{red: 1'b1, green: 1'b0, blue: 1'b0};
			3'd1: c = '{red: 1'b1, green: 1'b1, blue: 1'b1};
			3'd2: c = '{red: 1'b0, green: 1'b0, blue: 1'b1};
			3'd3: c = '{red: 1'b0, green: 1'b1, blue: 1'b0};
			3'd4: c = '{red: 1'b1, green: 1'b0, blue: 1'b1};
			default: c = '{red: 1'b0, green: 1'b0, blue: 1'b0};
		endcase
		return c;
	endfunction

endpackage

@@ src/ultrasonic_range_alarm.sv @@
// Top level of the ultrasonic range alarm: input register, sequencer, tone, result register.
// Depends on ura_pkg, ura_cfg, ura_ctrl and ura_tone.
//
//  channel | direction | handshake           | beat
//  in      | in        | in_valid / in_stall | echo_level, start_pressed, stop_pressed
//  out     | out       | out_valid/out_stall | trigger_out, LEDs, tone, band, width, flags
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// One beat per cycle sustained while not stalled; beats pass input then result register.
// All per-tick work sits between the input register and the result register.
// Reset clears the sequencer, tone counter and valid flags; limits return to defaults.
// An output stall holds the result register; in_stall is high while the input register
// also holds a beat, in the same cycle.
module ultrasonic_range_alarm #(
	parameter int ECHO_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        echo_level,
	input  logic        start_pressed,
	input  logic        stop_pressed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        trigger_out,
	output logic        red_on,
	output logic        green_on,
	output logic        blue_on,
	output logic        tone_out,
	output logic [2:0]  range_band,
	output logic        measure_done,
	output logic [15:0] echo_width,
	output logic        enabled,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic                valid_s1;
	logic                echo_s1, start_s1, stop_s1;
	logic                advance, accept;
	ura_pkg::limits_t    limits;
	logic [7:0]          trig_ticks;
	ura_pkg::ctrl_stat_t stat;
	logic                tone;
	ura_pkg::led_t       led;
	logic                out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			echo_s1  <= echo_level;
			start_s1 <= start_pressed;
			stop_s1  <= stop_pressed;
		end
	end

	ura_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.limits     (limits),
		.trig_ticks (trig_ticks)
	);

	ura_ctrl #(
		.ECHO_BITS (ECHO_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.echo       (echo_s1),
		.start      (start_s1),
		.stop       (stop_s1),
		.limits     (limits),
		.trig_ticks (trig_ticks),
		.stat       (stat)
	);

	ura_tone u_tone (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.band     (stat.band),
		.band_chg (stat.band_chg),
		.tone     (tone),
		.led      (led)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// hold the result beat while stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			trigger_out  <= stat.trig_out;
			red_on       <= led.red;
			green_on     <= led.green;
			blue_on      <= led.blue;
			tone_out     <= tone;
			range_band   <= stat.band;
			measure_done <= stat.done;
			echo_width   <= stat.echo_width;
			enabled      <= stat.run;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/ura_cfg.sv @@
// Configuration register file: five band limits and the trigger length.
// Depends on ura_pkg for register indexes and reset values.
module ura_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output ura_pkg::limits_t   limits,
	output logic [7:0]         trig_ticks
);

	ura_pkg::limits_t limits_q;
	logic [7:0]       trig_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q[0]  <= ura_pkg::RST_LIMIT_RED;
			limits_q[1]  <= ura_pkg::RST_LIMIT_WHITE;
			limits_q[2]  <= ura_pkg::RST_LIMIT_BLUE;
			limits_q[3]  <= ura_pkg::RST_LIMIT_GREEN;
			limits_q[4]  <= ura_pkg::RST_LIMIT_PINK;
			trig_ticks_q <= ura_pkg::RST_TRIG_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				ura_pkg::CFG_LIMIT_RED:     limits_q[0] <= cfg_data;
				ura_pkg::CFG_LIMIT_WHITE:   limits_q[1] <= cfg_data;
				ura_pkg::CFG_LIMIT_BLUE:    limits_q[2] <= cfg_data;
				ura_pkg::CFG_LIMIT_GREEN:   limits_q[3] <= cfg_data;
				ura_pkg::CFG_LIMIT_PINK:    limits_q[4] <= cfg_data;
				ura_pkg::CFG_TRIGGER_TICKS: trig_ticks_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign limits     = limits_q;
	assign trig_ticks = trig_ticks_q;

endmodule

@@ src/ura_ctrl.sv @@
// Measurement sequencer: enable flag, trigger pulse, echo width counter and band sort.
// Depends on ura_pkg for the band type, limits and the status struct.
module ura_ctrl #(
	parameter int ECHO_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 echo,
	input  logic                 start,
	input  logic                 stop,
	input  ura_pkg::limits_t     limits,
	input  logic [7:0]           trig_ticks,
	output ura_pkg::ctrl_stat_t  stat
);

	localparam int CMP_W = (ECHO_BITS > 16) ? ECHO_BITS : 16;
	localparam logic [ECHO_BITS-1:0] SAT = {ECHO_BITS{1'b1}};

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_MEAS
	} phase_t;

	phase_t                phase_q, phase_d;
	logic                  run_q, run_d;
	logic [7:0]            trig_cnt_q, trig_cnt_d;
	logic [7:0]            trig_inc;
	logic [7:0]            tlen;
	logic [ECHO_BITS-1:0]  echo_cnt_q, echo_cnt_d;
	ura_pkg::band_t        band_q, band_d, band_cls;
	logic                  done;
	logic [CMP_W-1:0]      w_ext;
	logic                  found;

	assign tlen     = (trig_ticks == 8'd0) ? 8'd1 : trig_ticks;
	assign trig_inc = trig_cnt_q + 8'd1;
	assign w_ext    = CMP_W'(echo_cnt_q);

	// Ordered band tests; first match wins
	always_comb begin
		band_cls = ura_pkg::BAND_OFF;
		found    = 1'b0;
		if (w_ext < CMP_W'(limits[0])) begin
			band_cls = 3'd0;
			found    = 1'b1;
		end
		for (int k = 1; k < 5; k++) begin
			if (!found && w_ext >= CMP_W'(limits[k-1]) && w_ext < CMP_W'(limits[k])) begin
				band_cls = 3'(k);
				found    = 1'b1;
			end
		end
	end

	always_comb begin
		phase_d    = phase_q;
		run_d      = run_q;
		trig_cnt_d = trig_cnt_q;
		echo_cnt_d = echo_cnt_q;
		band_d     = band_q;
		done       = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (stop) begin
					run_d  = 1'b0;
					band_d = ura_pkg::BAND_OFF;
				end
				if (start)
					run_d = 1'b1;
				if (run_d) begin
					phase_d    = PH_TRIG;
					trig_cnt_d = 8'd0;
				end
			end
			PH_TRIG: begin
				trig_cnt_d = trig_inc;
				if (trig_inc >= tlen || trig_inc == 8'd0)
					phase_d = PH_WAIT;
			end
			PH_WAIT: begin
				if (echo) begin
					echo_cnt_d = ECHO_BITS'(1);
					phase_d    = PH_MEAS;
				end
			end
			PH_MEAS: begin
				if (echo) begin
					// saturate at the counter maximum
					if (echo_cnt_q != SAT)
						echo_cnt_d = echo_cnt_q + ECHO_BITS'(1);
				end else begin
					band_d  = band_cls;
					done    = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			run_q      <= 1'b0;
			trig_cnt_q <= 8'd0;
			echo_cnt_q <= '0;
			band_q     <= ura_pkg::BAND_OFF;
		end else if (step) begin
			phase_q    <= phase_d;
			run_q      <= run_d;
			trig_cnt_q <= trig_cnt_d;
			echo_cnt_q <= echo_cnt_d;
			band_q     <= band_d;
		end
	end

	assign stat.trig_out   = (phase_q == PH_TRIG);
	assign stat.done       = done;
	assign stat.run        = run_d;
	assign stat.band       = band_d;
	assign stat.band_chg   = (band_d != band_q);
	assign stat.echo_width = 16'(CMP_W'(echo_cnt_d));

`ifndef SYNTH
	a_run_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> phase_q == PH_IDLE)
		else $error("sequencer left idle without the enable flag");

	a_trig_exit: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_TRIG |=> phase_q == PH_TRIG || phase_q == PH_WAIT)
		else $error("trigger phase left to a wrong phase");

	a_echo_rise: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_WAIT && echo |=> phase_q == PH_MEAS
			&& echo_cnt_q == ECHO_BITS'(1))
		else $error("echo rise did not restart the width count");

	a_band_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && (phase_q == PH_TRIG || phase_q == PH_WAIT) |=> $stable(band_q))
		else $error("band changed outside idle or measure end");
`endif

endmodule

@@ src/ura_tone.sv @@
// Buzzer square wave generator and LED color decode for the current band.
// Depends on ura_pkg for the tone tables and LED color function.
module ura_tone (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  ura_pkg::band_t  band,
	input  logic            band_chg,
	output logic            tone,
	output ura_pkg::led_t   led
);

	logic [ura_pkg::TONE_W-1:0] tone_cnt_q, tone_cnt_d, tc;

	always_comb begin
		// restart the period on a band change
		tc = band_chg ? '0 : tone_cnt_q;
		if (band < ura_pkg::BAND_OFF) begin
			tone       = (tc < ura_pkg::tone_high(band));
			tone_cnt_d = (tc >= ura_pkg::tone_wrap(band)) ? '0 : tc + 1'b1;
		end else begin
			tone       = 1'b0;
			tone_cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tone_cnt_q <= '0;
		else if (step)
			tone_cnt_q <= tone_cnt_d;
	end

	assign led = ura_pkg::led_color(band);

endmodule
